/* sv/running_mean_stddev_unit_macros.svh */
// Assertion helpers for the running mean / deviation unit
`ifndef RUNNING_MEAN_STDDEV_UNIT_MACROS_SVH
`define RUNNING_MEAN_STDDEV_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset
`define RMSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset
`define RMSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rmsd_pkg.sv */
package rmsd_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned FRAC_BITS   = 8;

  localparam int unsigned SUM_W       = SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned MAG_W       = SUM_W - 1;
  localparam int unsigned SQSUM_W     = 2 * SAMPLE_BITS - 2 + COUNT_BITS;
  localparam int unsigned PROD_W      = 2 * MAG_W;
  localparam int unsigned DEN_W       = 2 * COUNT_BITS;
  localparam int unsigned MEAN_W      = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned QUO_W       = 2 * MEAN_W - 1;
  localparam int unsigned STEP_W      = $clog2(QUO_W + 1);
  localparam int unsigned ROOT_STEP_W = $clog2(MEAN_W + 1);

  localparam int unsigned IN_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((COUNT_BITS + 2 * MEAN_W + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_STATS,
    ST_MEAN,
    ST_B,
    ST_DEN,
    ST_VAR,
    ST_ROOT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] mcand;
    logic [MAG_W-1:0]  mplier;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DEN_W-1:0]  rem;
    logic [QUO_W-1:0]  low;
    logic [DEN_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             start;
    logic [QUO_W-1:0] radicand;
  } root_req_t;

endpackage

/* sv/rmsd_mul.sv */
module rmsd_mul import rmsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mul_req_t          req_i,
  output logic              busy_o,
  output logic [PROD_W-1:0] prod_o
);

  logic [PROD_W-1:0] mcand_q, mcand_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [MAG_W-1:0]  mplier_q, mplier_d;

  assign busy_o = (mplier_q != '0);
  assign prod_o = acc_q;

  always_comb begin
    mcand_d  = mcand_q;
    acc_d    = acc_q;
    mplier_d = mplier_q;
    if (req_i.start) begin
      mcand_d  = req_i.mcand;
      mplier_d = req_i.mplier;
      acc_d    = '0;
    end else if (busy_o) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mplier_q <= '0;
    end else begin
      mplier_q <= mplier_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
  end

endmodule

/* sv/rmsd_div.sv */
module rmsd_div import rmsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             busy_o,
  output logic [QUO_W-1:0] quo_o
);

  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [QUO_W-1:0]  low_q, low_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [DEN_W-1:0]  dvs_q, dvs_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

  always_comb begin
    trial = {rem_q, low_q[QUO_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = rem_q;
    low_d = low_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    if (req_i.start) begin
      rem_d = req_i.rem;
      low_d = req_i.low;
      dvs_d = req_i.divisor;
      cnt_d = req_i.steps;
      quo_d = '0;
    end else if (busy_o) begin
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_d = low_q << 1;
      quo_d = {quo_q[QUO_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

endmodule

/* sv/rmsd_sqrt.sv */
module rmsd_sqrt import rmsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  root_req_t         req_i,
  output logic              busy_o,
  output logic [MEAN_W-1:0] root_o
);

  logic [2*MEAN_W-1:0]    rad_q, rad_d;
  logic [MEAN_W:0]        rem_q, rem_d;
  logic [MEAN_W-1:0]      root_q, root_d;
  logic [ROOT_STEP_W-1:0] cnt_q, cnt_d;
  logic [MEAN_W+2:0]      cur;
  logic [MEAN_W+2:0]      trial;
  logic [MEAN_W+2:0]      diff;
  logic                   ge;

  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;

  always_comb begin
    cur    = {rem_q, rad_q[2*MEAN_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    diff   = cur - trial;
    ge     = (cur >= trial);
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      rad_d  = (2*MEAN_W)'(req_i.radicand);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = ROOT_STEP_W'(MEAN_W);
    end else if (busy_o) begin
      rem_d  = ge ? diff[MEAN_W:0] : cur[MEAN_W:0];
      rad_d  = rad_q << 2;
      root_d = {root_q[MEAN_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

endmodule

/* sv/running_mean_stddev_unit.sv */
// A clear word goes straight to ST_OUT and on into the output register; a sample word
// passes the bit-serial multiplier, then 24 + 47 divide steps and 24 root steps, one
// bit or bit pair per cycle. One word in flight at a time;
// the next is taken once its predecessor's result sits in the output register.
// Reset (rst_ni low, asynchronous) empties the set and drops any pending result.
`include "running_mean_stddev_unit_macros.svh"

module running_mean_stddev_unit import rmsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [IN_W-1:0]  s_axis_tdata_i,   // sample
  input  logic             s_axis_tuser_i,   // cmd
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o,   // point_count, mean_value, std_deviation
  output logic [1:0]       m_axis_tuser_o    // set_empty, sample_dropped
);

  state_e                   state_q, state_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [SQSUM_W-1:0]       sq_q, sq_d;
  logic [COUNT_BITS-1:0]    cnt_q, cnt_d;
  logic                     drop_q, drop_d;
  logic [MEAN_W-1:0]        mean_q, mean_d;
  logic [MEAN_W-1:0]        sd_q, sd_d;
  logic [PROD_W-1:0]        diff_q, diff_d;
  logic                     m_valid_q, m_valid_d;
  logic [OUT_W-1:0]         m_data_q, m_data_d;
  logic [1:0]               m_user_q, m_user_d;

  logic                     s_accept;
  logic [SAMPLE_BITS-1:0]   sample;
  logic [SAMPLE_BITS-1:0]   smag;
  logic                     sum_neg;
  logic [SUM_W-1:0]         sum_abs;
  logic [MAG_W-1:0]         amag;
  logic [MEAN_W-1:0]        qmean;
  logic                     empty;

  mul_req_t                 mul_req;
  div_req_t                 div_req;
  root_req_t                root_req;
  logic                     mul_busy, div_busy, root_busy;
  logic [PROD_W-1:0]        mul_prod;
  logic [QUO_W-1:0]         div_quo;
  logic [MEAN_W-1:0]        root_val;

  rmsd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .busy_o (mul_busy),
    .prod_o (mul_prod)
  );

  rmsd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  rmsd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (root_req),
    .busy_o (root_busy),
    .root_o (root_val)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign sample          = s_axis_tdata_i[SAMPLE_BITS-1:0];
  assign smag            = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
  assign sum_neg         = sum_q[SUM_W-1];
  assign sum_abs         = sum_neg ? (~sum_q + 1'b1) : sum_q;
  assign amag            = sum_abs[MAG_W-1:0];
  assign qmean           = div_quo[MEAN_W-1:0];
  assign empty           = (cnt_q == '0);

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  always_comb begin
    state_d   = state_q;
    sum_d     = sum_q;
    sq_d      = sq_q;
    cnt_d     = cnt_q;
    drop_d    = drop_q;
    mean_d    = mean_q;
    sd_d      = sd_q;
    diff_d    = diff_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    mul_req   = '0;
    div_req   = '0;
    root_req  = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          if (s_axis_tuser_i == CMD_CLEAR) begin
            sum_d   = '0;
            sq_d    = '0;
            cnt_d   = '0;
            drop_d  = 1'b0;
            state_d = ST_OUT;
          end else if (cnt_q == COUNT_MAX) begin
            drop_d  = 1'b1;
            state_d = ST_STATS;
          end else begin
            drop_d         = 1'b0;
            sum_d          = sum_q + SUM_W'(signed'(sample));
            cnt_d          = cnt_q + 1'b1;
            mul_req.start  = 1'b1;
            mul_req.mcand  = PROD_W'(smag);
            mul_req.mplier = MAG_W'(smag);
            state_d        = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        if (!mul_busy) begin
          sq_d    = sq_q + SQSUM_W'(mul_prod);
          state_d = ST_STATS;
        end
      end
      ST_STATS: begin
        div_req.start   = 1'b1;
        div_req.rem     = DEN_W'(amag >> SAMPLE_BITS);
        div_req.low     = QUO_W'(amag[SAMPLE_BITS-1:0]) << (QUO_W - SAMPLE_BITS);
        div_req.divisor = DEN_W'(cnt_q);
        div_req.steps   = STEP_W'(MEAN_W);
        mul_req.start   = 1'b1;
        mul_req.mcand   = PROD_W'(sq_q);
        mul_req.mplier  = MAG_W'(cnt_q);
        state_d         = ST_MEAN;
      end
      ST_MEAN: begin
        if (!mul_busy && !div_busy) begin
          mean_d         = sum_neg ? (~qmean + 1'b1) : qmean;
          diff_d         = mul_prod;
          mul_req.start  = 1'b1;
          mul_req.mcand  = PROD_W'(amag);
          mul_req.mplier = amag;
          state_d        = ST_B;
        end
      end
      ST_B: begin
        if (!mul_busy) begin
          diff_d         = (diff_q > mul_prod) ? (diff_q - mul_prod) : '0;
          mul_req.start  = 1'b1;
          mul_req.mcand  = PROD_W'(cnt_q);
          mul_req.mplier = MAG_W'(cnt_q);
          state_d        = ST_DEN;
        end
      end
      ST_DEN: begin
        if (!mul_busy) begin
          div_req.start   = 1'b1;
          div_req.rem     = DEN_W'(diff_q >> (QUO_W - 2 * FRAC_BITS));
          div_req.low     = QUO_W'(diff_q[QUO_W-2*FRAC_BITS-1:0]) << (2 * FRAC_BITS);
          div_req.divisor = mul_prod[DEN_W-1:0];
          div_req.steps   = STEP_W'(QUO_W);
          state_d         = ST_VAR;
        end
      end
      ST_VAR: begin
        if (!div_busy) begin
          root_req.start    = 1'b1;
          root_req.radicand = div_quo;
          state_d           = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (!root_busy) begin
          sd_d    = root_val;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_W'({empty ? '0 : sd_q, empty ? '0 : mean_q, cnt_q});
          m_user_d  = {drop_q, empty};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sum_q     <= '0;
      sq_q      <= '0;
      cnt_q     <= '0;
      drop_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sum_q     <= sum_d;
      sq_q      <= sq_d;
      cnt_q     <= cnt_d;
      drop_q    <= drop_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q   <= mean_d;
    sd_q     <= sd_d;
    diff_q   <= diff_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  `RMSD_ASSERT_NEXT(a_accept_leaves_idle, s_accept, state_q != ST_IDLE, "accepted word left sequencer idle")
  `RMSD_ASSERT_NOW(a_empty_reads_zero, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o == '0, "empty set with nonzero statistics")
  `RMSD_ASSERT_NOW(a_drop_only_full, m_axis_tvalid_o && m_axis_tuser_o[1], m_axis_tdata_o[COUNT_BITS-1:0] == COUNT_MAX, "dropped sample below full count")
  `RMSD_ASSERT_NOW(a_units_idle, state_q == ST_IDLE, !mul_busy && !div_busy && !root_busy, "arithmetic unit busy while idle")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rmsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned HOLD_CYCLES = 2500;

  typedef struct packed {
    logic [COUNT_BITS-1:0] point_count;
    logic [MEAN_W-1:0]     mean_value;
    logic [MEAN_W-1:0]     std_deviation;
    logic                  set_empty;
    logic                  sample_dropped;
  } stats_t;

  typedef struct packed {
    cmd_e                          cmd;
    logic signed [SAMPLE_BITS-1:0] sample;
  } stat_word_t;

  typedef enum int unsigned {
    RUN_WIDE,
    RUN_NARROW,
    RUN_FLAT,
    RUN_EXTREME
  } run_style_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [IN_W-1:0]  s_axis_tdata_i = '0;  // sample
  logic             s_axis_tuser_i = 1'b0;  // cmd
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;  // point_count, mean_value, std_deviation
  logic [1:0]       m_axis_tuser_o;  // set_empty, sample_dropped

  stat_word_t  pending_words[$];
  stats_t      expected_stats[$];
  int unsigned words_total;
  int unsigned words_accepted = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  longint      set_sum;
  logic [63:0] set_square_sum;
  logic [63:0] set_count;

  int unsigned send_gap = 0;
  int unsigned send_quiet = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned recv_quiet = 0;

  running_mean_stddev_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 24);
    return $urandom_range(60, 300);
  endfunction

  // floor(num * 2^(2*FRAC_BITS) / den)
  function automatic logic [63:0] scaled_quotient(input logic [63:0] num, den);
    logic [63:0] quo, rem;
    quo = num / den;
    rem = num % den;
    for (int i = 0; i < 2 * FRAC_BITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] res, bitpair;
    res = '0;
    bitpair = 64'd1 << 62;
    while (bitpair > x) bitpair = bitpair >> 2;
    while (bitpair != 0) begin
      if (x >= res + bitpair) begin
        x = x - (res + bitpair);
        res = (res >> 1) + bitpair;
      end else begin
        res = res >> 1;
      end
      bitpair = bitpair >> 2;
    end
    return res;
  endfunction

  function automatic stats_t update_running_stats(input cmd_e cmd,
                                                  input logic signed [SAMPLE_BITS-1:0] sample);
    stats_t      r;
    longint      s;
    logic [63:0] mag, amag, quo, mean_wide, prod_a, prod_b;
    logic        neg;
    r = '0;
    s = sample;
    if (cmd == CMD_CLEAR) begin
      set_sum = 0;
      set_square_sum = '0;
      set_count = '0;
    end else if (set_count >= COUNT_MAX) begin
      r.sample_dropped = 1'b1;
    end else begin
      mag = (s < 0) ? 64'(-s) : 64'(s);
      set_sum = set_sum + s;
      set_square_sum = set_square_sum + mag * mag;
      set_count = set_count + 1;
    end
    r.point_count = set_count[COUNT_BITS-1:0];
    if (set_count == 0) begin
      r.set_empty = 1'b1;
    end else begin
      neg = set_sum < 0;
      amag = neg ? 64'(-set_sum) : 64'(set_sum);
      quo = (amag << FRAC_BITS) / set_count;
      mean_wide = neg ? (64'd0 - quo) : quo;
      r.mean_value = mean_wide[MEAN_W-1:0];
      prod_a = set_count * set_square_sum;
      prod_b = amag * amag;
      if (prod_a > prod_b) begin
        mean_wide = root_floor(scaled_quotient(prod_a - prod_b, set_count * set_count));
        r.std_deviation = mean_wide[MEAN_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  task automatic push_word(input cmd_e cmd, input logic signed [SAMPLE_BITS-1:0] sample);
    stat_word_t w;
    w.cmd = cmd;
    w.sample = sample;
    pending_words.push_back(w);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : driver
    stat_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= 1'b0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= w.sample;
        s_axis_tuser_i  <= w.cmd;
        if (send_quiet != 0) begin
          send_quiet--;
        end else begin
          send_gap = idle_length();
          if ($urandom_range(0, 30) == 0) send_quiet = 50;
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (cycle_count == 20000 || cycle_count == 150000) begin
      hold_left = HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (recv_quiet != 0) begin
        recv_quiet--;
      end else begin
        stall_left = ($urandom_range(0, 3) == 0) ? idle_length() : 0;
        if ($urandom_range(0, 40) == 0) recv_quiet = 500;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    stats_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_stats.push_back(update_running_stats(cmd_e'(s_axis_tuser_i),
                                                      s_axis_tdata_i[SAMPLE_BITS-1:0]));
        words_accepted <= words_accepted + 1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.point_count    = m_axis_tdata_o[COUNT_BITS-1:0];
        got.mean_value     = m_axis_tdata_o[COUNT_BITS +: MEAN_W];
        got.std_deviation  = m_axis_tdata_o[COUNT_BITS + MEAN_W +: MEAN_W];
        got.set_empty      = m_axis_tuser_o[0];
        got.sample_dropped = m_axis_tuser_o[1];
        if (expected_stats.size() == 0) begin
          $display("%0t: result word with nothing expected, got %h / %b",
                   $time, m_axis_tdata_o, m_axis_tuser_o);
          mismatch_count++;
        end else begin
          want = expected_stats.pop_front();
          check_field("point_count", want.point_count, got.point_count);
          check_field("mean_value", want.mean_value, got.mean_value);
          check_field("std_deviation", want.std_deviation, got.std_deviation);
          check_field("set_empty", want.set_empty, got.set_empty);
          check_field("sample_dropped", want.sample_dropped, got.sample_dropped);
        end
      end
    end
  end

  initial begin : stimulus
    run_style_e style;
    int unsigned run_len;
    int          base, value;
    logic signed [SAMPLE_BITS-1:0] extremes[3];

    extremes[0] = 16'sh8000;
    extremes[1] = 16'sh7fff;
    extremes[2] = 16'sh8001;

    // empty set, then the sign and magnitude extremes
    push_word(CMD_CLEAR, 16'sh7fff);
    push_word(CMD_ADD, 16'sh8000);
    push_word(CMD_ADD, 16'sh7fff);
    push_word(CMD_ADD, 0);
    push_word(CMD_ADD, -1);
    push_word(CMD_CLEAR, 16'sh8000);
    // single point, then a flat set
    push_word(CMD_ADD, 5);
    push_word(CMD_ADD, 5);
    push_word(CMD_ADD, 5);
    push_word(CMD_CLEAR, 0);
    push_word(CMD_ADD, 16'sh8000);
    push_word(CMD_ADD, 16'sh8000);
    push_word(CMD_ADD, 16'sh8000);
    push_word(CMD_CLEAR, -1);
    // negative means that truncate toward zero
    push_word(CMD_ADD, 1);
    push_word(CMD_ADD, -2);
    push_word(CMD_ADD, -2);
    push_word(CMD_ADD, 16'sh7fff);
    push_word(CMD_ADD, 16'sh8000);
    push_word(CMD_CLEAR, 16'sh5555);
    push_word(CMD_CLEAR, 16'shaaaa);

    while (pending_words.size() < 1700) begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                            : $urandom_range(1, 40);
      style = run_style_e'($urandom_range(0, 3));
      base = $signed(16'($urandom));
      for (int i = 0; i < run_len; i++) begin
        case (style)
          RUN_WIDE:    value = $signed(16'($urandom));
          RUN_NARROW:  value = base + int'($urandom_range(0, 31)) - 16;
          RUN_FLAT:    value = base;
          default:     value = extremes[$urandom_range(0, 2)];
        endcase
        push_word(CMD_ADD, value[SAMPLE_BITS-1:0]);
        if ($urandom_range(0, 60) == 0) push_word(CMD_CLEAR, 16'($urandom));
      end
      if ($urandom_range(0, 3) != 0) push_word(CMD_CLEAR, 16'($urandom));
    end
    words_total = pending_words.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (words_accepted != words_total || expected_stats.size() != 0);
    repeat (400) @(posedge clk_i);

    if (mismatch_count == 0 && expected_stats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
